>>> sv/bdshot_erpm_decode_defines.svh
// Assertion macros for the bidirectional DShot eRPM decoder.
`ifndef BDSHOT_ERPM_DECODE_DEFINES_SVH
`define BDSHOT_ERPM_DECODE_DEFINES_SVH

`ifndef SYNTHESIS
`define BDSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bdsd assertion failed");
`define BDSD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bdsd reset assertion failed");
`else
`define BDSD_ASSERT(lbl, prop)
`define BDSD_ASSERT_RST(lbl, prop)
`endif

`endif

>>> sv/bdsd_pkg.sv
// Shared types, constants and GCR map for the DShot eRPM decoder.
package bdsd_pkg;

  localparam int unsigned FRAME_W = 20;
  localparam int unsigned QUO_W   = 20;
  localparam int unsigned DVS_W   = 16;
  localparam int unsigned N_CELLS = QUO_W;

  localparam logic [QUO_W-1:0] ERPM_NUMER   = 20'd600000;
  localparam logic [11:0]      STOPPED_CODE = 12'hFFF;
  localparam logic [3:0]       CHK_GOOD     = 4'hF;

  typedef struct packed {
    logic             err;
    logic [QUO_W-1:0] num;
    logic [DVS_W-1:0] dvs;
    logic [DVS_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } bdsd_cell_t;

  // {bad, nibble}
  function automatic logic [4:0] gcr_decode(input logic [4:0] sym);
    logic [4:0] res;
    case (sym)
      5'd9:    res = {1'b0, 4'h9};
      5'd10:   res = {1'b0, 4'hA};
      5'd11:   res = {1'b0, 4'hB};
      5'd13:   res = {1'b0, 4'hD};
      5'd14:   res = {1'b0, 4'hE};
      5'd15:   res = {1'b0, 4'hF};
      5'd18:   res = {1'b0, 4'h2};
      5'd19:   res = {1'b0, 4'h3};
      5'd21:   res = {1'b0, 4'h5};
      5'd22:   res = {1'b0, 4'h6};
      5'd23:   res = {1'b0, 4'h7};
      5'd25:   res = {1'b0, 4'h0};
      5'd26:   res = {1'b0, 4'h8};
      5'd27:   res = {1'b0, 4'h1};
      5'd29:   res = {1'b0, 4'h4};
      5'd30:   res = {1'b0, 4'hC};
      default: res = {1'b1, 4'h0};
    endcase
    return res;
  endfunction

endpackage

>>> sv/bdshot_erpm_decode.sv
// Top level: bidirectional DShot telemetry frame to eRPM/100 decoder.
// Pipeline: 1 decode stage followed by 20 divider cells.
// Throughput: one frame per cycle unless the output stalls; the 20-cell divider chain is fully pipelined.
// A stalled output beat freezes the whole chain; synchronous active-low reset clears
// all valid bits.
`include "bdshot_erpm_decode_defines.svh"

module bdshot_erpm_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bdsd_pkg::FRAME_W-1:0] in_raw_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_frame_error,
  output logic [bdsd_pkg::QUO_W-1:0]   out_erpm_hundreds
);

  logic                 en;
  logic                 vld   [bdsd_pkg::N_CELLS+1];
  bdsd_pkg::bdsd_cell_t chain [bdsd_pkg::N_CELLS+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  bdsd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .raw      (in_raw_frame),
    .out_vld  (vld[0]),
    .out_data (chain[0])
  );

  for (genvar i = 0; i < bdsd_pkg::N_CELLS; i++) begin : g_cell
    bdsd_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld[i]),
      .in_data  (chain[i]),
      .out_vld  (vld[i+1]),
      .out_data (chain[i+1])
    );
  end

  assign out_valid         = vld[bdsd_pkg::N_CELLS];
  assign out_frame_error   = chain[bdsd_pkg::N_CELLS].err;
  assign out_erpm_hundreds = chain[bdsd_pkg::N_CELLS].quo;

  `BDSD_ASSERT(a_err_zero, (out_valid && out_frame_error) |-> (out_erpm_hundreds == '0))
  `BDSD_ASSERT(a_max_value, out_valid |-> (out_erpm_hundreds <= bdsd_pkg::ERPM_NUMER))
  `BDSD_ASSERT(a_accept_enters, (in_valid && in_ready) |=> vld[0])
  `BDSD_ASSERT_RST(a_reset_clears, !rst_n |=> !out_valid)

endmodule

>>> sv/bdsd_decode.sv
// Front stage: frame check, RLL/GCR decode, checksum and divider setup.
module bdsd_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [bdsd_pkg::FRAME_W-1:0]   raw,
  output logic                           out_vld,
  output bdsd_pkg::bdsd_cell_t           out_data
);

  logic [bdsd_pkg::FRAME_W-1:0] w;
  logic [bdsd_pkg::FRAME_W-1:0] d;
  logic [4:0]                   g0, g1, g2, g3;
  logic [15:0]                  word;
  logic                         sym_bad;
  logic                         chk_bad;
  logic [11:0]                  pay;
  logic                         stopped;
  logic [bdsd_pkg::DVS_W-1:0]   period;
  logic                         err;
  logic                         zero_out;
  bdsd_pkg::bdsd_cell_t         data_nxt;
  bdsd_pkg::bdsd_cell_t         data_r;
  logic                         vld_r;

  always_comb begin
    w       = ~raw;
    d       = w ^ (w >> 1);
    g0      = bdsd_pkg::gcr_decode(d[4:0]);
    g1      = bdsd_pkg::gcr_decode(d[9:5]);
    g2      = bdsd_pkg::gcr_decode(d[14:10]);
    g3      = bdsd_pkg::gcr_decode(d[19:15]);
    word    = {g3[3:0], g2[3:0], g1[3:0], g0[3:0]};
    sym_bad = g0[4] | g1[4] | g2[4] | g3[4];
    chk_bad = (g0[3:0] ^ g1[3:0] ^ g2[3:0] ^ g3[3:0]) != bdsd_pkg::CHK_GOOD;
    pay     = word[15:4];
    stopped = (pay == bdsd_pkg::STOPPED_CODE);
    period  = bdsd_pkg::DVS_W'(pay[8:0]) << pay[11:9];
    err     = !w[0] | sym_bad | chk_bad | (!stopped && period == '0);
    zero_out = err | stopped;

    data_nxt.err = err;
    data_nxt.num = zero_out ? '0
                 : bdsd_pkg::ERPM_NUMER + bdsd_pkg::QUO_W'(period[bdsd_pkg::DVS_W-1:1]);
    data_nxt.dvs = zero_out ? bdsd_pkg::DVS_W'(1) : period;
    data_nxt.rem = '0;
    data_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

>>> sv/bdsd_div_cell.sv
// One restoring division step: yields one quotient bit per cell.
`include "bdshot_erpm_decode_defines.svh"

module bdsd_div_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  bdsd_pkg::bdsd_cell_t in_data,
  output logic                 out_vld,
  output bdsd_pkg::bdsd_cell_t out_data
);

  logic [bdsd_pkg::DVS_W:0]   trial;
  logic [bdsd_pkg::DVS_W:0]   diff;
  logic                       ge;
  bdsd_pkg::bdsd_cell_t       data_nxt;
  bdsd_pkg::bdsd_cell_t       data_r;
  logic                       vld_r;

  always_comb begin
    trial = {in_data.rem, in_data.num[bdsd_pkg::QUO_W-1]};
    diff  = trial - {1'b0, in_data.dvs};
    ge    = trial >= {1'b0, in_data.dvs};

    data_nxt.err = in_data.err;
    data_nxt.dvs = in_data.dvs;
    data_nxt.num = {in_data.num[bdsd_pkg::QUO_W-2:0], 1'b0};
    data_nxt.rem = ge ? diff[bdsd_pkg::DVS_W-1:0] : trial[bdsd_pkg::DVS_W-1:0];
    data_nxt.quo = {in_data.quo[bdsd_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

  `BDSD_ASSERT(a_rem_below_dvs, vld_r |-> (data_r.rem < data_r.dvs))
  `BDSD_ASSERT(a_hold_on_stall, !en |=> $stable(vld_r))
  `BDSD_ASSERT(a_err_passes, (en && in_vld) |=> (data_r.err == $past(in_data.err)))

endmodule

>>> tb/sv/bdshot_erpm_decode_checker.sv
// Checker for the DShot eRPM decoder: predicts each frame's result and compares beats.
`timescale 1ns / 100ps

module erpm_decode_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [bdsd_pkg::FRAME_W-1:0] in_raw_frame,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         out_frame_error,
  input  logic [bdsd_pkg::QUO_W-1:0]   out_erpm_hundreds,
  output int                           fail_count,
  output int                           pending
);

  localparam logic [15:0][4:0] QUINT_OF_NIB = {
    5'd15, 5'd14, 5'd13, 5'd30, 5'd11, 5'd10, 5'd9,  5'd26,
    5'd23, 5'd22, 5'd21, 5'd29, 5'd19, 5'd18, 5'd27, 5'd25
  };
  localparam logic [4:0] SYM_BAD = 5'h10;

  typedef struct packed {
    logic [bdsd_pkg::FRAME_W-1:0] frame;
    logic                         err;
    logic [bdsd_pkg::QUO_W-1:0]   erpm;
  } erpm_result_t;

  erpm_result_t erpm_q[$];
  erpm_result_t want;
  int           nfail = 0;
  int           npend = 0;

  assign fail_count = nfail;
  assign pending    = npend;

  function automatic logic [4:0] nibble_of_quintet(input logic [4:0] q);
    for (int n = 0; n < 16; n++) begin
      if (QUINT_OF_NIB[n] == q) return {1'b0, 4'(n)};
    end
    return SYM_BAD;
  endfunction

  function automatic erpm_result_t decode_telemetry(input logic [bdsd_pkg::FRAME_W-1:0] raw);
    erpm_result_t                 res;
    logic [bdsd_pkg::FRAME_W-1:0] w;
    logic [4:0]                   sym;
    logic [15:0]                  word;
    logic [11:0]                  pay;
    int unsigned                  period;
    res       = '0;
    res.frame = raw;
    w         = ~raw;
    word      = '0;
    if (!w[0]) begin
      res.err = 1'b1;
      return res;
    end
    w = w ^ (w >> 1);
    for (int k = 0; k < 4; k++) begin
      sym = nibble_of_quintet(w[5*k +: 5]);
      if (sym == SYM_BAD) begin
        res.err = 1'b1;
        return res;
      end
      word[4*k +: 4] = sym[3:0];
    end
    if ((word[3:0] ^ word[7:4] ^ word[11:8] ^ word[15:12]) != bdsd_pkg::CHK_GOOD) begin
      res.err = 1'b1;
      return res;
    end
    pay = word[15:4];
    if (pay == bdsd_pkg::STOPPED_CODE) return res;
    period = 32'(pay[8:0]) << pay[11:9];
    if (period == 0) begin
      res.err = 1'b1;
      return res;
    end
    res.erpm = bdsd_pkg::QUO_W'((32'(bdsd_pkg::ERPM_NUMER) + period / 2) / period);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned wanted, input logic [19:0] frame);
    $display("%0t: mismatch on %0s: got %0d, want %0d (frame %05h)",
             $time, what, got, wanted, frame);
    nfail++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) erpm_q.push_back(decode_telemetry(in_raw_frame));
      if (out_valid && out_ready) begin
        if (erpm_q.size() == 0) begin
          report_mismatch("beat with no frame pending", 32'(out_erpm_hundreds), 0, '0);
        end else begin
          want = erpm_q.pop_front();
          if (out_frame_error !== want.err)
            report_mismatch("frame_error", 32'(out_frame_error), 32'(want.err), want.frame);
          if (out_erpm_hundreds !== want.erpm)
            report_mismatch("erpm_hundreds", 32'(out_erpm_hundreds), 32'(want.erpm),
                            want.frame);
        end
      end
      npend = erpm_q.size();
    end
  end

endmodule

>>> tb/sv/bdshot_erpm_decode_tb.sv
// Testbench top for the DShot eRPM decoder: clock, reset, frame stimulus and verdict.
`timescale 1ns / 100ps

module bdshot_erpm_decode_tb;

  localparam int IDLE_LIMIT = 4000;
  localparam int N_RANDOM   = 1350;
  localparam logic [15:0][4:0] QUINT_OF_NIB = {
    5'd15, 5'd14, 5'd13, 5'd30, 5'd11, 5'd10, 5'd9,  5'd26,
    5'd23, 5'd22, 5'd21, 5'd29, 5'd19, 5'd18, 5'd27, 5'd25
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [bdsd_pkg::FRAME_W-1:0] in_raw_frame;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_frame_error;
  logic [bdsd_pkg::QUO_W-1:0]   out_erpm_hundreds;
  int                           fail_count;
  int                           pending;
  int                           idle_cycles = 0;

  bdshot_erpm_decode uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_raw_frame      (in_raw_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_error   (out_frame_error),
    .out_erpm_hundreds (out_erpm_hundreds)
  );

  erpm_decode_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_raw_frame      (in_raw_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_error   (out_frame_error),
    .out_erpm_hundreds (out_erpm_hundreds),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Build a line frame from a payload; flip corrupts the checksum nibble.
  function automatic logic [19:0] encode_frame(input logic [11:0] pay, input logic [3:0] flip);
    logic [15:0] word;
    logic [19:0] r;
    logic [19:0] w;
    word = {pay, ~(pay[3:0] ^ pay[7:4] ^ pay[11:8]) ^ flip};
    for (int k = 0; k < 4; k++) r[5*k +: 5] = QUINT_OF_NIB[word[4*k +: 4]];
    w[19] = r[19];
    for (int i = 18; i >= 0; i--) w[i] = r[i] ^ w[i+1];
    return ~w;
  endfunction

  function automatic logic [11:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return {3'($urandom), 9'($urandom_range(0, 3))};
    if (r < 15) return bdsd_pkg::STOPPED_CODE;
    if (r < 20) return {3'($urandom), 9'h1FF - 9'($urandom_range(0, 3))};
    return 12'($urandom);
  endfunction

  task automatic send_frame(input logic [19:0] frame);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 85) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_raw_frame <= frame;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drive out_ready in runs; hold off once for a long stretch to fill the pipe.
  initial begin : sink
    int r;
    int len;
    int cyc;
    logic rdy;
    logic held;
    cyc       = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && cyc >= 600) begin
        rdy  = 1'b0;
        len  = 300;
        held = 1'b1;
      end else if (r < 60) begin
        rdy = 1'b1;
        len = $urandom_range(1, 12);
      end else if (r < 90) begin
        rdy = 1'b0;
        len = $urandom_range(1, 4);
      end else if (r < 96) begin
        rdy = 1'b1;
        len = $urandom_range(30, 100);
      end else begin
        rdy = 1'b0;
        len = $urandom_range(15, 50);
      end
      @(negedge clk);
      out_ready <= rdy;
      repeat (len - 1) @(negedge clk);
      cyc += len;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    logic [19:0] frame;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_raw_frame = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_frame(20'h00000);
    send_frame(20'hFFFFF);
    send_frame(20'hFFFFE);
    send_frame(20'h55555);
    send_frame(20'hAAAAA);
    send_frame(encode_frame(bdsd_pkg::STOPPED_CODE, 4'h0));
    send_frame(encode_frame(12'h001, 4'h0));
    send_frame(encode_frame(12'h002, 4'h0));
    send_frame(encode_frame(12'h003, 4'h0));
    send_frame(encode_frame(12'h000, 4'h0));
    send_frame(encode_frame(12'h200, 4'h0));
    send_frame(encode_frame(12'hE00, 4'h0));
    send_frame(encode_frame(12'h201, 4'h0));
    send_frame(encode_frame(12'h1FF, 4'h0));
    send_frame(encode_frame(12'hFFE, 4'h0));
    send_frame(encode_frame(12'hDFF, 4'h0));
    send_frame(encode_frame(12'h7A5, 4'h0));
    send_frame(encode_frame(12'hC36, 4'h0));
    send_frame(encode_frame(12'h123, 4'h1));
    send_frame(encode_frame(bdsd_pkg::STOPPED_CODE, 4'h8));
    send_frame(encode_frame(12'h001, 4'h0) ^ 20'h80000);
    send_frame(encode_frame(12'h001, 4'h0) ^ 20'h00400);

    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) frame = encode_frame(pick_payload(), 4'h0);
      else if (r < 78) frame = encode_frame(pick_payload(), 4'($urandom_range(1, 15)));
      else if (r < 86) frame = encode_frame(pick_payload(), 4'h0) ^ (20'h1 << $urandom_range(0, 19));
      else frame = 20'($urandom);
      send_frame(frame);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/bdsd_pkg.sv
sv/bdsd_decode.sv
sv/bdsd_div_cell.sv
sv/bdshot_erpm_decode.sv
tb/sv/bdshot_erpm_decode_checker.sv
tb/sv/bdshot_erpm_decode_tb.sv
